[hdl/soc_pkg.sv]
package soc_pkg;

  localparam int unsigned MaxPatternDef = 8;
  localparam int unsigned CountBitsDef  = 16;

  // Width of an active pattern length, enough for lengths up to 16.
  localparam int unsigned LenW   = 5;
  localparam int unsigned PaddrW = 5;
  localparam int unsigned PdataW = 64;
  localparam int unsigned OutW   = 16;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] RegPattern = 2'd0;
  localparam logic [1:0] RegLength  = 2'd1;
  localparam logic [1:0] RegOverlap = 2'd2;

  typedef struct packed {
    logic [63:0] pattern;
    logic [3:0]  length;
    logic        overlap;
  } cfg_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [LenW-1:0] active_len(input logic [3:0] len,
                                                 input int unsigned max_len);
    logic [LenW-1:0] res;
    if (len == 4'd0) begin
      res = LenW'(1);
    end else if (32'(len) > max_len) begin
      res = LenW'(max_len);
    end else begin
      res = LenW'(len);
    end
    return res;
  endfunction

endpackage

[hdl/soc_text_if.sv]
interface soc_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

[hdl/soc_count_if.sv]
interface soc_count_if;
  logic        valid;
  logic        ready;
  logic [15:0] match_count;

  modport source (output valid, output match_count, input ready);
  modport sink (input valid, input match_count, output ready);
endinterface

[hdl/soc_match.sv]
module soc_match #(
  parameter int unsigned MAX_PATTERN = soc_pkg::MaxPatternDef
) (
  input  logic [63:0]                      pattern_i,
  input  logic [soc_pkg::LenW-1:0]         len_i,
  input  logic [$clog2(MAX_PATTERN+1)-1:0] seen_i,
  input  logic [7:0]                       cur_i,
  input  logic [7:0]                       recent_i [(MAX_PATTERN > 1 ? MAX_PATTERN-1 : 1)],
  output logic                             match_o
);

  localparam int unsigned Hist   = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int unsigned HistIw = (Hist > 1) ? $clog2(Hist) : 1;
  localparam int unsigned PatIw  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [7:0]              pat_b [MAX_PATTERN];
  logic [Hist-1:0]         ok;
  logic [soc_pkg::LenW-1:0] last_idx;

  // Pattern positions past the 64-bit register read as zero.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_pat
    if (k < 8) begin : g_held
      assign pat_b[k] = pattern_i[8*k +: 8];
    end else begin : g_zero
      assign pat_b[k] = 8'd0;
    end
  end

  // Pattern byte k pairs with the byte that arrived len-1-k bytes ago.
  for (genvar k = 0; k < Hist; k++) begin : g_cmp
    logic [soc_pkg::LenW-1:0] sel;
    assign sel   = len_i - soc_pkg::LenW'(k + 2);
    assign ok[k] = (soc_pkg::LenW'(k + 1) >= len_i) ||
                   (recent_i[sel[HistIw-1:0]] == pat_b[k]);
  end

  assign last_idx = len_i - soc_pkg::LenW'(1);

  assign match_o = (soc_pkg::LenW'(seen_i) >= last_idx) &&
                   (pat_b[last_idx[PatIw-1:0]] == cur_i) && (&ok);

endmodule

[hdl/substring_occurrence_counter.sv]
// Counts the occurrences of a 1 to 8 byte pattern in a text that arrives one
// byte per request, the last byte flagged with end_of_text. The pattern,
// its length and the overlap mode sit in APB registers at 0x0, 0x8 and 0x10;
// the user must write them while the block is idle; it does not enforce that.
// One byte is taken every clock but in the stall below: the byte passes an
// input register, the window of recent bytes is compared with the pattern
// combinationally, and the count of the last byte is written to the output
// register as that byte moves on. It saturates at 65535. The only stall is a
// last byte waiting in the input register while an earlier count is still
// held at the output. The window, byte tally and count clear after each text.
module substring_occurrence_counter #(
  parameter int unsigned MAX_PATTERN = soc_pkg::MaxPatternDef,
  parameter int unsigned COUNT_BITS  = soc_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  soc_text_if.sink                     text_i,
  soc_count_if.source                  count_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [soc_pkg::PaddrW-1:0]   paddr,
  input  logic [soc_pkg::PdataW-1:0]   pwdata,
  output logic [soc_pkg::PdataW-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned Hist  = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;
  localparam int unsigned SeenW = $clog2(MAX_PATTERN + 1);

  soc_pkg::cfg_t cfg_q;

  logic                   s1_valid_q;
  logic [7:0]             s1_byte_q;
  logic                   s1_last_q;

  logic [7:0]             recent_q [Hist];
  logic [SeenW-1:0]       seen_q;
  logic [2:0]             blocked_q;
  logic [COUNT_BITS-1:0]  count_q;

  logic                   out_valid_q;
  logic [soc_pkg::OutW-1:0] out_count_q;

  logic                   advance;
  logic                   match;
  logic                   sat;
  logic [soc_pkg::LenW-1:0] len;
  logic [COUNT_BITS-1:0]  count_d;
  logic [2:0]             blocked_d;
  logic [soc_pkg::OutW-1:0] count_clip;

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern <= 64'd0;
      cfg_q.length  <= 4'd1;
      cfg_q.overlap <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:3])
        soc_pkg::RegPattern: cfg_q.pattern <= pwdata;
        soc_pkg::RegLength:  cfg_q.length  <= pwdata[3:0];
        soc_pkg::RegOverlap: cfg_q.overlap <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      soc_pkg::RegPattern: prdata = cfg_q.pattern;
      soc_pkg::RegLength:  prdata = {60'd0, cfg_q.length};
      soc_pkg::RegOverlap: prdata = {63'd0, cfg_q.overlap};
      default:             prdata = '0;
    endcase
  end

  // A byte moves on unless it carries a count and the output is still held.
  assign advance      = s1_valid_q && (!s1_last_q || !out_valid_q || count_o.ready);
  assign text_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (text_i.ready) begin
      s1_valid_q <= text_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.valid && text_i.ready) begin
      s1_byte_q <= text_i.text_byte;
      s1_last_q <= text_i.end_of_text;
    end
  end

  assign len = soc_pkg::active_len(cfg_q.length, MAX_PATTERN);

  soc_match #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_match (
    .pattern_i (cfg_q.pattern),
    .len_i     (len),
    .seen_i    (seen_q),
    .cur_i     (s1_byte_q),
    .recent_i  (recent_q),
    .match_o   (match)
  );

  assign sat = &count_q;

  always_comb begin
    count_d   = count_q;
    blocked_d = blocked_q;
    if (cfg_q.overlap) begin
      blocked_d = 3'd0;
      if (match && !sat) begin
        count_d = count_q + COUNT_BITS'(1);
      end
    end else if (blocked_q != 3'd0) begin
      blocked_d = blocked_q - 3'd1;
    end else if (match) begin
      if (!sat) begin
        count_d = count_q + COUNT_BITS'(1);
      end
      // Positions still inside this match cannot end a counted one.
      blocked_d = 3'(len - soc_pkg::LenW'(1));
    end
  end

  if (COUNT_BITS > soc_pkg::OutW) begin : g_clip
    assign count_clip = (count_d > COUNT_BITS'({soc_pkg::OutW{1'b1}})) ?
                        {soc_pkg::OutW{1'b1}} : count_d[soc_pkg::OutW-1:0];
  end else begin : g_ext
    assign count_clip = soc_pkg::OutW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Hist; k++) begin
        recent_q[k] <= 8'd0;
      end
      seen_q    <= '0;
      blocked_q <= 3'd0;
      count_q   <= '0;
    end else if (advance) begin
      if (s1_last_q) begin
        for (int k = 0; k < Hist; k++) begin
          recent_q[k] <= 8'd0;
        end
        seen_q    <= '0;
        blocked_q <= 3'd0;
        count_q   <= '0;
      end else begin
        for (int k = Hist - 1; k > 0; k--) begin
          recent_q[k] <= recent_q[k-1];
        end
        recent_q[0] <= s1_byte_q;
        if (seen_q < SeenW'(MAX_PATTERN)) begin
          seen_q <= seen_q + SeenW'(1);
        end
        blocked_q <= blocked_d;
        count_q   <= count_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (count_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_last_q) begin
      out_count_q <= count_clip;
    end
  end

  assign count_o.valid       = out_valid_q;
  assign count_o.match_count = out_count_q;

endmodule

[hdl/soc_checker.sv]
module soc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_count_i
);

  // A held count stays put until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_count_i))
    else $error("count changed or dropped while stalled");

  // With the output slot empty, nothing may hold back the text side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("text request refused with empty output");

  // A fresh count must be preceded by an accepted text request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("count without a matching request");

endmodule

bind substring_occurrence_counter soc_checker u_soc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (text_i.valid),
  .in_ready_i  (text_i.ready),
  .out_valid_i (count_o.valid),
  .out_ready_i (count_o.ready),
  .out_count_i (count_o.match_count)
);

[tb/tb_substring_occurrence_counter.sv]
`timescale 1ns / 100ps

module tb_substring_occurrence_counter;

  localparam int CycleLimit  = 400000;
  localparam int RandomBytes = 1400;
  localparam int NumDirected = 28;

  typedef enum logic {RowCfg, RowByte} row_kind_e;
  typedef enum logic [1:0] {RecvOpen, RecvRandom, RecvSparse, RecvBursty} recv_mode_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [63:0] value;
    logic        last;
    logic        pinned;
    logic [15:0] count;
  } stim_row_t;

  // Pinned rows carry a count readable straight off the behavior.
  stim_row_t directed_rows [NumDirected] = '{
    '{RowByte, soc_pkg::RegPattern, 64'h41, 1'b1, 1'b1, 16'd0},   // reset pattern is a zero byte
    '{RowByte, soc_pkg::RegPattern, 64'h00, 1'b1, 1'b1, 16'd1},   // zero byte compares too
    '{RowCfg,  soc_pkg::RegPattern, 64'h6161, 1'b0, 1'b0, 16'd0},
    '{RowCfg,  soc_pkg::RegLength,  64'd2, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'h61, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'h61, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'h61, 1'b1, 1'b0, 16'd0},
    '{RowCfg,  soc_pkg::RegOverlap, 64'd0, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'h61, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'h61, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'h61, 1'b1, 1'b0, 16'd0},
    '{RowCfg,  soc_pkg::RegLength,  64'd0, 1'b0, 1'b0, 16'd0},    // length zero acts as one
    '{RowByte, soc_pkg::RegPattern, 64'h61, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'h62, 1'b1, 1'b0, 16'd0},
    '{RowCfg,  soc_pkg::RegPattern, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 16'd0},
    '{RowCfg,  soc_pkg::RegLength,  64'd15, 1'b0, 1'b0, 16'd0},   // clamps to the full window
    '{RowCfg,  soc_pkg::RegOverlap, 64'd1, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'hFF, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'hFF, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'hFF, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'hFF, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'hFF, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'hFF, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'hFF, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'hFF, 1'b1, 1'b1, 16'd1},
    '{RowByte, soc_pkg::RegPattern, 64'hFF, 1'b0, 1'b0, 16'd0},   // text shorter than pattern
    '{RowByte, soc_pkg::RegPattern, 64'hFF, 1'b0, 1'b0, 16'd0},
    '{RowByte, soc_pkg::RegPattern, 64'hFF, 1'b1, 1'b1, 16'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [soc_pkg::PaddrW-1:0] paddr;
  logic [soc_pkg::PdataW-1:0] pwdata;
  logic [soc_pkg::PdataW-1:0] prdata;
  logic                       pready;

  soc_text_if  text_bus ();
  soc_count_if count_bus ();

  substring_occurrence_counter u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_bus),
    .count_o (count_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Scanner copy: config plus window state.
  soc_pkg::cfg_t model_cfg;
  logic [7:0]  recent_text [0:7];
  int unsigned text_seen;
  int unsigned skip_left;
  int unsigned hits;

  logic [15:0] pending_counts [$];
  logic [15:0] predicted_count;
  logic [15:0] oldest_count;
  bit          pin_valid;
  logic [15:0] pin_count;
  bit          mismatch_seen;
  int          burst_left;
  int unsigned cycle_count;
  int unsigned bytes_accepted;
  int unsigned texts_done;
  int unsigned counts_checked;
  int unsigned reg_writes;
  int unsigned rand_sent;

  recv_mode_e  recv_mode;
  int unsigned recv_hold;
  int unsigned recv_tick;

  function automatic int unsigned eff_len();
    if (model_cfg.length == 4'd0) begin
      return 1;
    end else if (model_cfg.length > 4'd8) begin
      return 8;
    end
    return model_cfg.length;
  endfunction

  function automatic void clear_scan();
    for (int k = 0; k < 8; k++) begin
      recent_text[k] = 8'h00;
    end
    text_seen = 0;
    skip_left = 0;
    hits      = 0;
  endfunction

  function automatic bit scan_byte(input logic [7:0] cur, input logic last,
                                   output logic [15:0] res);
    int unsigned len;
    bit          hit;
    len = eff_len();
    hit = (text_seen + 1 >= len) && (model_cfg.pattern[8*(len-1) +: 8] == cur);
    for (int k = 0; k + 1 < len; k++) begin
      if (recent_text[len-2-k] != model_cfg.pattern[8*k +: 8]) begin
        hit = 1'b0;
      end
    end
    if (model_cfg.overlap) begin
      skip_left = 0;
      if (hit && hits < 65535) begin
        hits++;
      end
    end else if (skip_left != 0) begin
      skip_left--;
    end else if (hit) begin
      if (hits < 65535) begin
        hits++;
      end
      skip_left = (len - 1) & 7;
    end
    for (int k = 7; k > 0; k--) begin
      recent_text[k] = recent_text[k-1];
    end
    recent_text[0] = cur;
    if (text_seen < 8) begin
      text_seen++;
    end
    res = 16'(hits);
    if (last) begin
      clear_scan();
    end
    return last;
  endfunction

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (text_bus.valid && text_bus.ready) begin
        bytes_accepted++;
        if (scan_byte(text_bus.text_byte, text_bus.end_of_text, predicted_count)) begin
          texts_done++;
          pending_counts.push_back(pin_valid ? pin_count : predicted_count);
        end
      end
      if (count_bus.valid && count_bus.ready) begin
        if (pending_counts.size() == 0) begin
          $error("match_count: expected none, actual %0d", count_bus.match_count);
          mismatch_seen = 1'b1;
        end else begin
          oldest_count = pending_counts.pop_front();
          counts_checked++;
          if (count_bus.match_count !== oldest_count) begin
            $error("match_count: expected %0d, actual %0d", oldest_count,
                   count_bus.match_count);
            mismatch_seen = 1'b1;
          end
        end
      end
    end
  end

  // Result side: the stall pattern switches between modes after a random hold.
  always @(negedge clk_i) begin
    if (recv_hold == 0) begin
      recv_mode = recv_mode_e'($urandom_range(0, 3));
      recv_hold = $urandom_range(20, 200);
    end
    recv_hold--;
    recv_tick++;
    case (recv_mode)
      RecvOpen:   count_bus.ready <= 1'b1;
      RecvRandom: count_bus.ready <= 1'($urandom_range(0, 1));
      RecvSparse: count_bus.ready <= (recv_tick % 6 == 0);
      default:    count_bus.ready <= (recv_tick % 16 >= 10);
    endcase
  end

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      soc_pkg::RegPattern: model_cfg.pattern = data;
      soc_pkg::RegLength:  model_cfg.length  = data[3:0];
      soc_pkg::RegOverlap: model_cfg.overlap = data[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Called and returns at a falling edge.
  task automatic push_text_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        text_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    text_bus.valid       <= 1'b1;
    text_bus.text_byte   <= b;
    text_bus.end_of_text <= last;
    @(posedge clk_i);
    while (!text_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained(input int settle);
    text_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_counts.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  // Texts lean on pattern bytes and whole pattern copies to reach matches.
  task automatic send_random_text();
    int          n;
    int          i;
    int unsigned act;
    logic [7:0]  b;
    act = eff_len();
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
    i = 0;
    while (i < n) begin
      if ($urandom_range(0, 3) == 0) begin
        for (int k = 0; k < act && i < n; k++) begin
          b = model_cfg.pattern[8*k +: 8];
          if (b == 8'h00) begin
            b = 8'($urandom_range(1, 255));
          end
          i++;
          rand_sent++;
          push_text_byte(b, i == n);
        end
      end else begin
        case ($urandom_range(0, 2))
          0:       b = model_cfg.pattern[8*$urandom_range(0, act-1) +: 8];
          1:       b = 8'($urandom_range(1, 255));
          default: b = 8'h61 + 8'($urandom_range(0, 1));
        endcase
        if (b == 8'h00) begin
          b = 8'($urandom_range(1, 255));
        end
        i++;
        rand_sent++;
        push_text_byte(b, i == n);
      end
    end
  endtask

  initial begin
    logic [63:0] pat;
    logic [7:0]  fill;
    int          pick;
    rst_ni               = 1'b0;
    text_bus.valid       = 1'b0;
    text_bus.text_byte   = 8'h00;
    text_bus.end_of_text = 1'b0;
    count_bus.ready      = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    model_cfg.pattern    = '0;
    model_cfg.length     = 4'd1;
    model_cfg.overlap    = 1'b1;
    clear_scan();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NumDirected; r++) begin
      if (directed_rows[r].kind == RowCfg) begin
        wait_drained(4);
        write_reg(directed_rows[r].reg_idx, directed_rows[r].value);
      end else begin
        pin_valid = directed_rows[r].pinned;
        pin_count = directed_rows[r].count;
        push_text_byte(directed_rows[r].value[7:0], directed_rows[r].last);
      end
    end
    pin_valid = 1'b0;

    while (rand_sent < RandomBytes) begin
      wait_drained(4);
      case ($urandom_range(0, 5))
        0: pat = '1;
        1: pat = '0;
        2: begin
          fill = 8'($urandom_range(1, 255));
          pat  = {8{fill}};
        end
        default: begin
          for (int k = 0; k < 8; k++) begin
            pat[8*k +: 8] = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255))
                                                        : 8'h61 + 8'($urandom_range(0, 1));
          end
        end
      endcase
      write_reg(soc_pkg::RegPattern, pat);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        write_reg(soc_pkg::RegLength, 64'd0);
      end else if (pick == 1) begin
        write_reg(soc_pkg::RegLength, 64'($urandom_range(9, 15)));
      end else begin
        write_reg(soc_pkg::RegLength, 64'($urandom_range(1, 8)));
      end
      write_reg(soc_pkg::RegOverlap, 64'($urandom_range(0, 1)));
      repeat ($urandom_range(3, 10)) begin
        send_random_text();
        if ($urandom_range(0, 5) == 0) begin
          wait_drained(0);
        end
      end
    end

    wait_drained(8);
    $display("Run covered %0d texts over %0d bytes, %0d counts checked, %0d register writes,",
             texts_done, bytes_accepted, counts_checked, reg_writes);
    $display("with both overlap modes, zero and clamped lengths, and random output stalls.");
    if (!mismatch_seen) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/soc_pkg.sv
hdl/soc_text_if.sv
hdl/soc_count_if.sv
hdl/soc_match.sv
hdl/substring_occurrence_counter.sv
hdl/soc_checker.sv
tb/tb_substring_occurrence_counter.sv
